// ===== rtl/core/mgsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Max-gap slot allocator package
// Types and codes shared by the allocator's cells, its scanner and the top level.
// ----------------------------------------------------------------------------
package mgsa_pkg;

    // Width of a row position with room for the row length itself (up to 64).
    localparam int POS_W = 7;
    // Width of the configured row length register.
    localparam int CFG_W = 7;

    localparam logic CMD_CLAIM   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_CLAIMED  = 2'd0,
        ST_RELEASED = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic       cmd;
        logic [5:0] slot;
    } t_item;

    typedef struct packed {
        logic [5:0] chosen_slot;
        t_status    status;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    // Control of one occupancy cell.
    typedef struct packed {
        logic shift;
        logic set;
        logic clr;
    } t_cell_ctl;

    // Control of the gap scanner.
    typedef struct packed {
        logic clear;
        logic step;
    } t_scan_ctl;

    // Outcome of a scan.
    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] pick;
    } t_scan_res;

endpackage

// ===== rtl/core/max_gap_slot_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Max-gap slot allocator
// Keeps a slot occupancy bitmap and grants the free slot farthest from its neighbors.
// ----------------------------------------------------------------------------
// A release leaves busy low; o_result shows its result word with o_done high in the
// cycle after start. A claim holds busy high while the scanner walks all CELLS cells
// (the smaller of SLOTS and 64) and through the done state; its result word follows
// in the next cycle, and no new command is taken while busy is high. Claims are
// paced by the occupancy ring: the bits sit in a ring of cells that rotates by one
// slot per cycle past a single gap scanner, and a full turn brings the ring back
// into place before the granted bit is set. The result strobe o_done lasts exactly
// one cycle and cannot be held off, so the receiver must take every word when it
// appears. The row length register is written through i_cfg_valid/o_cfg_ready and
// should only change while no command is in flight; values outside 1..CELLS act as
// the nearest bound.
module max_gap_slot_allocator_unit #(
    parameter int SLOTS = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  mgsa_pkg::t_item                i_item,
    output logic                           o_done,
    output mgsa_pkg::t_result              o_result,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mgsa_pkg::CFG_W-1:0]     i_cfg_data
);
    import mgsa_pkg::*;

    // Only the first 64 slots can ever be addressed or scanned.
    localparam int CELLS = (SLOTS < 64) ? SLOTS : 64;
    localparam int CW    = $clog2(CELLS);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [CFG_W-1:0] r_slot_count;
    logic             r_done, n_done;
    t_result          r_result, n_result;

    logic [POS_W-1:0] row_len;
    logic             accept;
    logic             do_release;
    logic             do_set;
    t_scan_ctl        scan_ctl;
    t_scan_res        scan_res;
    logic [CELLS-1:0] occ;
    t_cell_ctl        cell_ctl [CELLS];

    assign accept     = start && !busy;
    assign do_release = accept && (i_item.cmd == CMD_RELEASE);
    assign busy       = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Effective row length: the register clamped to 1..CELLS.
    always_comb begin
        row_len = r_slot_count;
        if (r_slot_count == '0) begin
            row_len = POS_W'(1);
        end else if (r_slot_count > POS_W'(CELLS)) begin
            row_len = POS_W'(CELLS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= CFG_W'(64);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_slot_count <= i_cfg_data;
        end
    end

    // The occupancy ring. Each cell takes the bit of the next higher cell on
    // a rotation, so after k rotations cell 0 holds the bit of slot k.
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        localparam int NXT = (k + 1) % CELLS;

        always_comb begin
            cell_ctl[k].shift = (r_state == S_SCAN);
            cell_ctl[k].set   = do_set && (scan_res.pick == POS_W'(k));
            cell_ctl[k].clr   = do_release && ({1'b0, i_item.slot} == POS_W'(k));
        end

        mgsa_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl[k]),
            .i_bit   (occ[NXT]),
            .o_occ   (occ[k])
        );
    end

    assign scan_ctl.clear = accept && (i_item.cmd == CMD_CLAIM);
    assign scan_ctl.step  = (r_state == S_SCAN);

    mgsa_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_bit     (occ[0]),
        .i_idx     (POS_W'(r_cnt)),
        .i_row_len (row_len),
        .o_res     (scan_res)
    );

    // Once the ring has turned fully, the bit of the granted slot is set.
    assign do_set = (r_state == S_DONE) && scan_res.found;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_result = r_result;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.cmd == CMD_RELEASE) begin
                        n_done               = 1'b1;
                        n_result.chosen_slot = i_item.slot;
                        n_result.status      = ST_RELEASED;
                    end else begin
                        n_state = S_SCAN;
                        n_cnt   = '0;
                    end
                end
            end
            S_SCAN: begin
                n_cnt = r_cnt + CW'(1);
                if (r_cnt == CW'(CELLS - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
                n_done  = 1'b1;
                if (scan_res.found) begin
                    n_result.chosen_slot = scan_res.pick[5:0];
                    n_result.status      = ST_CLAIMED;
                end else begin
                    n_result.chosen_slot = '0;
                    n_result.status      = ST_FULL;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A result word only follows a finished scan or an accepted release.
    a_done_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past((r_state == S_DONE) || do_release))
        else $error("result word without a finished command");

    // Every scan starts at slot zero.
    a_scan_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && ($past(r_state) == S_IDLE)) |-> (r_cnt == '0))
        else $error("scan did not start at slot zero");

    // A granted slot lies inside the effective row.
    a_grant_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_CLAIMED)) |->
            ({1'b0, o_result.chosen_slot} < row_len))
        else $error("granted slot outside the row");

endmodule

// ===== rtl/core/mgsa_cell.sv =====
// ----------------------------------------------------------------------------
// Occupancy cell
// Holds the occupancy bit of one slot and takes its neighbor's bit when the row rotates.
// ----------------------------------------------------------------------------
module mgsa_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mgsa_pkg::t_cell_ctl i_ctl,
    input  logic                i_bit,
    output logic                o_occ
);
    import mgsa_pkg::*;

    logic r_occ;
    logic n_occ;

    always_comb begin
        n_occ = r_occ;
        if (i_ctl.clr) begin
            n_occ = 1'b0;
        end else if (i_ctl.set) begin
            n_occ = 1'b1;
        end else if (i_ctl.shift) begin
            n_occ = i_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    assign o_occ = r_occ;

endmodule

// ===== rtl/core/mgsa_scan.sv =====
// ----------------------------------------------------------------------------
// Gap scanner
// Walks the occupancy bits one slot per cycle and tracks the widest gap found.
// ----------------------------------------------------------------------------
module mgsa_scan (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  mgsa_pkg::t_scan_ctl          i_ctl,
    input  logic                         i_bit,
    input  logic [mgsa_pkg::POS_W-1:0]   i_idx,
    input  logic [mgsa_pkg::POS_W-1:0]   i_row_len,
    output mgsa_pkg::t_scan_res          o_res
);
    import mgsa_pkg::*;

    logic             r_any, n_any;
    logic             r_found, n_found;
    logic [POS_W-1:0] r_prev, n_prev;
    logic [POS_W-1:0] r_best, n_best;
    logic [POS_W-1:0] r_pick, n_pick;
    logic [POS_W-1:0] half;
    logic [POS_W-1:0] last;
    logic [POS_W-1:0] tail;

    // Half of the distance between the previous occupied slot and this one.
    assign half = (i_idx - r_prev) >> 1;

    always_comb begin
        n_any   = r_any;
        n_found = r_found;
        n_prev  = r_prev;
        n_best  = r_best;
        n_pick  = r_pick;
        if (i_ctl.clear) begin
            n_any   = 1'b0;
            n_found = 1'b0;
            n_prev  = '0;
            n_best  = '0;
            n_pick  = '0;
        end else if (i_ctl.step && i_bit && (i_idx < i_row_len)) begin
            if (!r_any) begin
                // The left end is an open gap reaching to the first occupied slot.
                if (i_idx != '0) begin
                    n_best  = i_idx;
                    n_pick  = '0;
                    n_found = 1'b1;
                end
            end else if (half > r_best) begin
                n_best  = half;
                n_pick  = r_prev + half;
                n_found = 1'b1;
            end
            n_any  = 1'b1;
            n_prev = i_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any   <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_any   <= n_any;
            r_found <= n_found;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        r_best <= n_best;
        r_pick <= n_pick;
    end

    // The right end is an open gap from the last occupied slot to the row's end.
    assign last = i_row_len - POS_W'(1);
    assign tail = last - r_prev;

    always_comb begin
        o_res.found = r_found;
        o_res.pick  = r_pick;
        if (!r_any) begin
            o_res.found = 1'b1;
            o_res.pick  = '0;
        end else if ((r_prev < last) && (tail > r_best)) begin
            o_res.found = 1'b1;
            o_res.pick  = last;
        end
    end

endmodule
